// ===== sv/slpp_pkg.sv =====
package slpp_pkg;

  // Highest number of parts in one server list (part numbers 0 .. MaxParts-1).
  localparam int MaxParts = 32;
  localparam int PartIdxW = (MaxParts > 1) ? $clog2(MaxParts) : 1;
  localparam int PartCntW = $clog2(MaxParts + 1);

  // Output queue depth; two free slots are needed to process one byte.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Response codes and markers carried in the packet.
  localparam logic [31:0] RespBanned       = 32'd3;
  localparam logic [31:0] RespBad          = 32'd4;
  localparam logic [31:0] RespWrongVersion = 32'd5;
  localparam logic [31:0] RespBeginPart    = 32'd6;
  localparam logic [7:0]  RespEnd          = 8'd2;
  localparam logic [7:0]  RespEndPart      = 8'd7;

  typedef enum logic [2:0] {
    StGood    = 3'd0,
    StPending = 3'd1,
    StBad     = 3'd2,
    StBanned  = 3'd3,
    StWait    = 3'd4,
    StOld     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PhCode,
    PhPart,
    PhFirst,
    PhCount,
    PhIp,
    PhPortLo,
    PhPortHi,
    PhMark
  } phase_e;

  typedef enum logic {
    KindEntry  = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [15:0] port_number;
    status_e     status;
    logic        last_result;
  } out_t;

  // Results produced by one processed byte.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } res_bundle_t;

endpackage

// ===== sv/slpp_parser.sv =====
module slpp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  slpp_pkg::in_t        item_i,
  output slpp_pkg::res_bundle_t res_o
);
  import slpp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [1:0]            byte_idx_q, byte_idx_d;
  logic [31:0]           code_q, code_d;
  logic [MaxParts-1:0]   seen_q, seen_d;
  logic [PartCntW-1:0]   total_q, total_d;
  logic                  final_q, final_d;
  logic [31:0]           addr_q, addr_d;
  logic [7:0]            ports_left_q, ports_left_d;
  logic [7:0]            port_low_q, port_low_d;
  logic                  decided_q, decided_d;

  logic [MaxParts-1:0]   all_mask;
  logic                  set_good;
  logic [31:0]           code_new;
  logic [8:0]            part_plus;
  logic [7:0]            ports_dec;
  logic                  sw_valid;
  out_t                  sw_res;
  out_t                  bad_res;

  // Mask of every part number below the current part total.
  always_comb begin
    for (int i = 0; i < MaxParts; i++) begin
      all_mask[i] = (PartCntW'(i) < total_q);
    end
  end

  // A closing marker gives good once the final part is in and no part is missing.
  assign set_good  = (final_q || (item_i.data_byte == RespEnd)) && (seen_q == all_mask);
  assign code_new  = code_q | (32'(item_i.data_byte) << {byte_idx_q, 3'b000});
  assign part_plus = {1'b0, item_i.data_byte} + 9'd1;
  assign ports_dec = (ports_left_q != 8'd0) ? (ports_left_q - 8'd1) : 8'd0;

  always_comb begin
    bad_res             = '0;
    bad_res.kind        = KindStatus;
    bad_res.status      = StBad;
    bad_res.last_result = 1'b1;
  end

  // Byte step: next state and the result of the current phase.
  always_comb begin
    phase_d      = phase_q;
    byte_idx_d   = byte_idx_q;
    code_d       = code_q;
    seen_d       = seen_q;
    total_d      = total_q;
    final_d      = final_q;
    addr_d       = addr_q;
    ports_left_d = ports_left_q;
    port_low_d   = port_low_q;
    decided_d    = decided_q;
    sw_valid     = 1'b0;
    sw_res       = '0;
    sw_res.kind  = KindStatus;
    sw_res.status = StPending;
    res_o        = '0;

    if (item_i.mode) begin
      // Refresh start clears the part record and abandons the packet.
      seen_d       = '0;
      total_d      = '0;
      final_d      = 1'b0;
      phase_d      = PhCode;
      byte_idx_d   = '0;
      code_d       = '0;
      addr_d       = '0;
      ports_left_d = '0;
      port_low_d   = '0;
      decided_d    = 1'b0;
    end else begin
      if (!decided_q) begin
        unique case (phase_q)
          PhCode: begin
            code_d = code_new;
            if (byte_idx_q == 2'd3) begin
              byte_idx_d = '0;
              if (code_new == RespBeginPart) begin
                phase_d = PhPart;
              end else begin
                sw_valid  = 1'b1;
                decided_d = 1'b1;
                if (code_new == RespBanned) begin
                  sw_res.status = StBanned;
                end else if (code_new == RespBad) begin
                  sw_res.status = StWait;
                end else if (code_new == RespWrongVersion) begin
                  sw_res.status = StOld;
                end else begin
                  sw_res.status = StPending;
                end
              end
            end else begin
              byte_idx_d = byte_idx_q + 2'd1;
            end
          end
          PhPart: begin
            if (item_i.data_byte >= 8'(MaxParts)) begin
              sw_valid      = 1'b1;
              decided_d     = 1'b1;
              sw_res.status = StBad;
            end else if (seen_q[item_i.data_byte[PartIdxW-1:0]]) begin
              sw_valid      = 1'b1;
              decided_d     = 1'b1;
              sw_res.status = StPending;
            end else begin
              seen_d[item_i.data_byte[PartIdxW-1:0]] = 1'b1;
              if (part_plus > 9'(total_q)) begin
                total_d = part_plus[PartCntW-1:0];
              end
              phase_d = PhFirst;
            end
          end
          PhFirst: begin
            if ((item_i.data_byte == RespEnd) || (item_i.data_byte == RespEndPart)) begin
              if (item_i.data_byte == RespEnd) begin
                final_d = 1'b1;
              end
              sw_valid      = 1'b1;
              decided_d     = 1'b1;
              sw_res.status = set_good ? StGood : StPending;
            end else begin
              phase_d = PhCount;
            end
          end
          PhCount: begin
            if (item_i.data_byte == 8'd0) begin
              phase_d = PhMark;
            end else begin
              ports_left_d = item_i.data_byte;
              addr_d       = '0;
              byte_idx_d   = '0;
              phase_d      = PhIp;
            end
          end
          PhIp: begin
            addr_d = {addr_q[23:0], item_i.data_byte};
            if (byte_idx_q == 2'd3) begin
              byte_idx_d = '0;
              phase_d    = PhPortLo;
            end else begin
              byte_idx_d = byte_idx_q + 2'd1;
            end
          end
          PhPortLo: begin
            port_low_d = item_i.data_byte;
            phase_d    = PhPortHi;
          end
          PhPortHi: begin
            sw_valid           = 1'b1;
            sw_res.kind        = KindEntry;
            sw_res.address     = addr_q;
            sw_res.port_number = {item_i.data_byte, port_low_q};
            sw_res.status      = StGood;
            ports_left_d       = ports_dec;
            phase_d            = (ports_dec == 8'd0) ? PhCount : PhPortLo;
          end
          PhMark: begin
            if (item_i.data_byte == RespEnd) begin
              final_d = 1'b1;
            end
            sw_valid      = 1'b1;
            decided_d     = 1'b1;
            sw_res.status = set_good ? StGood : StPending;
          end
          default: begin
            sw_valid      = 1'b1;
            decided_d     = 1'b1;
            sw_res.status = StBad;
          end
        endcase
      end

      // Packet end: an undecided packet gives bad, then the packet state restarts.
      if (item_i.end_of_packet) begin
        if (!decided_d) begin
          if (sw_valid) begin
            res_o.cnt = 2'd2;
            res_o.r0  = sw_res;
            res_o.r1  = bad_res;
          end else begin
            res_o.cnt = 2'd1;
            res_o.r0  = bad_res;
          end
        end else if (sw_valid) begin
          res_o.cnt = 2'd1;
          res_o.r0  = sw_res;
          res_o.r0.last_result = 1'b1;
        end
        phase_d      = PhCode;
        byte_idx_d   = '0;
        code_d       = '0;
        addr_d       = '0;
        ports_left_d = '0;
        port_low_d   = '0;
        decided_d    = 1'b0;
      end else if (sw_valid) begin
        res_o.cnt = 2'd1;
        res_o.r0  = sw_res;
        res_o.r0.last_result = 1'b1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhCode;
      byte_idx_q   <= '0;
      code_q       <= '0;
      seen_q       <= '0;
      total_q      <= '0;
      final_q      <= 1'b0;
      addr_q       <= '0;
      ports_left_q <= '0;
      port_low_q   <= '0;
      decided_q    <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      byte_idx_q   <= byte_idx_d;
      code_q       <= code_d;
      seen_q       <= seen_d;
      total_q      <= total_d;
      final_q      <= final_d;
      addr_q       <= addr_d;
      ports_left_q <= ports_left_d;
      port_low_q   <= port_low_d;
      decided_q    <= decided_d;
    end
  end

  // Every packet end leaves the parser waiting for a fresh response code.
  a_eop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.end_of_packet) |=> (phase_q == PhCode && !decided_q))
    else $error("packet end did not restart the parser");

  // A second result is only ever the early-end status.
  a_second_is_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.cnt == 2'd2) |-> (res_o.r1.status == StBad && res_o.r0.kind == KindEntry))
    else $error("unexpected second result");

  // A decided packet gives nothing more until its end.
  a_quiet_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && decided_q && !item_i.end_of_packet) |-> (res_o.cnt == 2'd0))
    else $error("result after the packet status");

endmodule

// ===== sv/slpp_out_queue.sv =====
module slpp_out_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  slpp_pkg::res_bundle_t   push_i,
  output logic [slpp_pkg::QCntW-1:0] free_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output slpp_pkg::out_t          out_data_o
);
  import slpp_pkg::*;

  out_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_next;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = QCntW'(QDepth) - cnt_q + QCntW'(pop);
  assign wr_next     = wr_q + QPtrW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i.cnt);
    rd_d  = rd_q + QPtrW'(pop);
    cnt_d = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage; the second result of a byte goes into the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (QCntW'(push_i.cnt) <= free_o))
    else $error("output queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= QCntW'(QDepth)))
    else $error("output queue count out of range");

  // A full queue with nothing leaving takes no new results.
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == QCntW'(QDepth) && !pop) |-> (push_i.cnt == 2'd0))
    else $error("push into a full output queue");

endmodule

// ===== sv/server_list_packet_parser_top.sv =====
// The input register holds an accepted byte until the output queue has room for both
// of its possible results; the parser then processes it and the queue offers its results.
// Throughput: one byte per cycle while the output queue has room, limited by the output
// port at one result per cycle; a byte that gives an entry and a status yields two results.
// Reset: rst_ni clears the part record, the packet state and the output queue.
module server_list_packet_parser_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  slpp_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output slpp_pkg::out_t   out_data_o
);
  import slpp_pkg::*;

  in_t              in_q;
  logic             in_valid_q, in_valid_d;
  logic             step;
  logic             accept;
  logic [QCntW-1:0] free;
  res_bundle_t      res;
  res_bundle_t      push;

  // The held byte is parsed once the queue has room for both possible results.
  assign step       = in_valid_q && (free >= QCntW'(2));
  assign in_ready_o = !in_valid_q || step;
  assign accept     = in_valid_i && in_ready_o;
  assign in_valid_d = accept || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  slpp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  // Only a byte that is really processed pushes results.
  always_comb begin
    push = res;
    if (!step) begin
      push.cnt = 2'd0;
    end
  end

  slpp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/server_list_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the server list parser, predicts the results of
// every accepted request and compares each accepted result with the oldest
// prediction.
module server_list_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  slpp_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  slpp_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             outstanding_o
);
  import slpp_pkg::*;

  localparam int MaxReports = 10;

  // Predicted parser state.
  phase_e      ph;
  logic [1:0]  byte_idx;
  logic [31:0] code_acc;
  logic [63:0] parts_seen;
  int          part_total;
  logic        final_seen;
  logic [31:0] blk_addr;
  logic [7:0]  ports_left;
  logic [7:0]  blk_size;
  logic [7:0]  port_lo;
  logic        decided;

  out_t step_batch[$];
  out_t awaited_results[$];
  out_t want;
  int   errs;

  // Forget the packet in progress; the part record is kept.
  task automatic clear_packet();
    ph         = PhCode;
    byte_idx   = 2'd0;
    code_acc   = '0;
    blk_addr   = '0;
    ports_left = '0;
    blk_size   = '0;
    port_lo    = '0;
    decided    = 1'b0;
  endtask

  task automatic emit_result(input kind_e k, input logic [31:0] a, input logic [15:0] p,
                             input status_e s);
    out_t r;
    r.kind        = k;
    r.address     = a;
    r.port_number = p;
    r.status      = s;
    r.last_result = 1'b0;
    step_batch.push_back(r);
  endtask

  task automatic decide_status(input status_e s);
    emit_result(KindStatus, 32'd0, 16'd0, s);
    decided = 1'b1;
  endtask

  // A closing marker gives good only when the final part has been seen and
  // every part below the highest one has arrived.
  task automatic close_packet(input logic [7:0] marker);
    logic [63:0] all_parts;
    all_parts = (part_total >= 64) ? '1 : ((64'd1 << part_total) - 64'd1);
    if (marker == RespEnd) final_seen = 1'b1;
    if (final_seen && parts_seen == all_parts) decide_status(StGood);
    else decide_status(StPending);
  endtask

  // Work out the results of one accepted byte and queue them.
  task automatic parse_reply_byte(input in_t it);
    logic [7:0] b;
    out_t       r;
    b = it.data_byte;
    step_batch.delete();
    if (it.mode) begin
      // A refresh start clears the part record and drops the packet.
      parts_seen = '0;
      part_total = 0;
      final_seen = 1'b0;
      clear_packet();
    end else begin
      if (!decided) begin
        case (ph)
          PhCode: begin
            code_acc = code_acc | ({24'd0, b} << (8 * byte_idx));
            if (byte_idx == 2'd3) begin
              byte_idx = 2'd0;
              if (code_acc == RespBanned) decide_status(StBanned);
              else if (code_acc == RespBad) decide_status(StWait);
              else if (code_acc == RespWrongVersion) decide_status(StOld);
              else if (code_acc != RespBeginPart) decide_status(StPending);
              else ph = PhPart;
            end else begin
              byte_idx = byte_idx + 2'd1;
            end
          end
          PhPart: begin
            if (int'(b) >= MaxParts || int'(b) >= 64) begin
              decide_status(StBad);
            end else if (parts_seen[b[5:0]]) begin
              decide_status(StPending);
            end else begin
              parts_seen[b[5:0]] = 1'b1;
              if (int'(b) + 1 > part_total) part_total = int'(b) + 1;
              ph = PhFirst;
            end
          end
          PhFirst: begin
            if (b == RespEnd || b == RespEndPart) close_packet(b);
            else ph = PhCount;
          end
          PhCount: begin
            if (b == 8'd0) begin
              ph = PhMark;
            end else begin
              blk_size   = b;
              ports_left = b;
              blk_addr   = '0;
              byte_idx   = 2'd0;
              ph         = PhIp;
            end
          end
          PhIp: begin
            blk_addr = {blk_addr[23:0], b};
            if (byte_idx == 2'd3) begin
              byte_idx = 2'd0;
              ph       = PhPortLo;
            end else begin
              byte_idx = byte_idx + 2'd1;
            end
          end
          PhPortLo: begin
            port_lo = b;
            ph      = PhPortHi;
          end
          PhPortHi: begin
            emit_result(KindEntry, blk_addr, {b, port_lo}, StGood);
            if (ports_left > 8'd0) ports_left = ports_left - 8'd1;
            ph = (ports_left == 8'd0) ? PhCount : PhPortLo;
          end
          PhMark: begin
            close_packet(b);
          end
          default: begin
            decide_status(StBad);
          end
        endcase
      end
      // The last byte of a packet that has not given a status yet gives bad.
      if (it.end_of_packet) begin
        if (!decided) decide_status(StBad);
        clear_packet();
      end
    end
    for (int i = 0; i < step_batch.size(); i++) begin
      r = step_batch[i];
      r.last_result = (i == step_batch.size() - 1);
      awaited_results.push_back(r);
    end
  endtask

  // Predict on accepted requests and compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parts_seen = '0;
      part_total = 0;
      final_seen = 1'b0;
      clear_packet();
      awaited_results.delete();
      errs = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_reply_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          errs++;
          if (errs <= MaxReports) begin
            $display("unexpected result: kind %0d addr %h port %h status %0d last %0b",
                     out_data_i.kind, out_data_i.address, out_data_i.port_number,
                     out_data_i.status, out_data_i.last_result);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i !== want) begin
            errs++;
            if (errs <= MaxReports) begin
              $display("mismatch: expected kind %0d addr %h port %h status %0d last %0b",
                       want.kind, want.address, want.port_number, want.status,
                       want.last_result);
              $display("          actual   kind %0d addr %h port %h status %0d last %0b",
                       out_data_i.kind, out_data_i.address, out_data_i.port_number,
                       out_data_i.status, out_data_i.last_result);
            end
          end
        end
      end
      fail_count_o  <= errs;
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Drives packet bytes and refresh starts into the server list parser and
// gives the verdict from the checker's failure count.
module testbench;
  import slpp_pkg::*;

  localparam int TotalItems    = 1900;
  localparam int QuietFrom     = 1650;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  int fail_count;
  int outstanding;
  int idle_pct    = 20;
  int stall_left  = 0;
  int quiet_count = 0;
  int bytes_sent  = 0;

  logic [7:0] pkt_bytes[$];

  server_list_packet_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  server_list_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready_i <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(1, 16);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Stop the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Drive one request, after an optional idle burst, and hold it until taken.
  task automatic send_byte(input logic m, input logic [7:0] b, input logic eop);
    in_t item;
    item.mode          = m;
    item.data_byte     = b;
    item.end_of_packet = eop;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic add_code(input logic [31:0] code);
    for (int i = 0; i < 4; i++) pkt_bytes.push_back(code[8*i +: 8]);
  endtask

  // Send the packet buffer; a cut at or above zero that lies inside the buffer ends the packet there.
  task automatic send_packet(input int cut);
    int last;
    last = (cut < 0 || cut >= pkt_bytes.size()) ? pkt_bytes.size() - 1 : cut;
    for (int i = 0; i <= last; i++) send_byte(1'b0, pkt_bytes[i], i == last);
    pkt_bytes.delete();
  endtask

  // Most packets go out whole; some are cut short at a random byte.
  function automatic int pick_cut();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, pkt_bytes.size() - 1);
    return -1;
  endfunction

  // Build a begin-part packet with the given number of server blocks.
  task automatic build_part_packet(input logic [7:0] part, input logic [7:0] marker,
                                   input int nblocks);
    logic [7:0] opener;
    int         cnt;
    pkt_bytes.delete();
    add_code(RespBeginPart);
    pkt_bytes.push_back(part);
    if (nblocks == 0 && $urandom_range(0, 1) == 1) begin
      pkt_bytes.push_back(marker);
    end else begin
      do begin
        opener = 8'($urandom_range(0, 255));
      end while (opener == RespEnd || opener == RespEndPart);
      pkt_bytes.push_back(opener);
      repeat (nblocks) begin
        cnt = ($urandom_range(0, 49) == 0) ? $urandom_range(4, 255) : $urandom_range(1, 3);
        pkt_bytes.push_back(8'(cnt));
        repeat (4 + 2 * cnt) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      pkt_bytes.push_back(8'd0);
      pkt_bytes.push_back(marker);
    end
    // Bytes after the status are ignored by the block.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int         k;
    int         j;
    int         tmp;
    int         base;
    int         end_at;
    int         next_switch;
    int         order[8];
    logic [7:0] marker;
    logic [31:0] code;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each response code, early ends, part limits and a duplicate.
    send_byte(1'b1, 8'hFF, 1'b1);
    add_code(RespBanned);
    send_packet(-1);
    add_code(RespBad);
    send_packet(-1);
    add_code(RespWrongVersion);
    send_packet(-1);
    add_code(32'hFFFF_FFFF);
    send_packet(1);
    build_part_packet(8'hFF, RespEnd, 0);
    send_packet(4);
    build_part_packet(8'(MaxParts), RespEnd, 0);
    send_packet(4);
    build_part_packet(8'd0, RespEnd, 0);
    send_packet(-1);
    build_part_packet(8'd0, RespEndPart, 0);
    send_packet(4);
    // A port that completes on the last byte gives an entry and then bad.
    build_part_packet(8'd1, RespEnd, 1);
    send_packet(12);

    // Random part: mostly whole part lists, with noise and broken packets.
    next_switch = 0;
    while (bytes_sent < TotalItems) begin
      if (bytes_sent >= QuietFrom) begin
        idle_pct = 0;
      end else if (bytes_sent >= next_switch) begin
        next_switch += 150;
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          // A refresh followed by every part of a list in random order.
          send_byte(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          k = $urandom_range(1, 6);
          base = ($urandom_range(0, 9) == 0) ? MaxParts - k : 0;
          for (int i = 0; i < k; i++) order[i] = base + i;
          for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          end_at = $urandom_range(0, k - 1);
          for (int i = 0; i < k; i++) begin
            marker = (i == end_at) ? RespEnd : RespEndPart;
            build_part_packet(8'(order[i]), marker, $urandom_range(0, 2));
            send_packet(pick_cut());
          end
          if ($urandom_range(0, 3) == 0) begin
            build_part_packet(8'(order[0]), RespEnd, $urandom_range(0, 1));
            send_packet(pick_cut());
          end
        end
        12, 13, 14: begin
          // A lone part with any number and any closing marker.
          j = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, MaxParts + 7);
          case ($urandom_range(0, 2))
            0:       marker = RespEnd;
            1:       marker = RespEndPart;
            default: marker = 8'($urandom_range(0, 255));
          endcase
          build_part_packet(8'(j), marker, $urandom_range(0, 3));
          send_packet(pick_cut());
        end
        15, 16: begin
          // A packet with a random response code, usually not begin-part.
          case ($urandom_range(0, 4))
            0:       code = RespBanned;
            1:       code = RespBad;
            2:       code = RespWrongVersion;
            3:       code = 32'($urandom_range(0, 8));
            default: code = $urandom;
          endcase
          add_code(code);
          repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          send_packet(pick_cut());
        end
        17, 18: begin
          // Noise: random bytes with random packet ends.
          repeat ($urandom_range(1, 12)) begin
            send_byte(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          end
        end
        default: begin
          send_byte(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      endcase
    end

    // Let every predicted result come out, then allow for late extras.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/slpp_pkg.sv
sv/slpp_parser.sv
sv/slpp_out_queue.sv
sv/server_list_packet_parser_top.sv
tb/server_list_checker.sv
tb/testbench.sv
